// ===== rtl/core/bpdc_pkg.sv =====
package bpdc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INDICATOR_HOLD = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd50;
	localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd500;
	localparam logic [CFG_W-1:0] INDICATOR_HOLD_RST = 16'd1000;

	typedef struct packed {
		logic done;
		logic is_short;
	} press_evt_t;

endpackage

// ===== rtl/core/button_press_duration_classifier_unit.sv =====
// An accepted request is held in the sample register, then its result in the result register.
// Throughput: one request per cycle while out_ready does not stall the output; the sample
// and result registers each hold one request, and the state update sets this rate.
// Reset: arst_n clears the press state machine, the indicators, both pipeline
// valid flags and loads the registers with debounce 50, short limit 500, hold 1000.
module button_press_duration_classifier_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bpdc_pkg::TIME_W-1:0]         time_ms,
	input  logic                                button_low,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                press_done,
	output logic [bpdc_pkg::TIME_W-1:0]         press_length,
	output logic                                press_short,
	output logic                                green_light,
	output logic                                red_light,
	input  logic                                cfg_wen,
	input  logic [bpdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpdc_pkg::CFG_W-1:0]          cfg_data
);

	logic [bpdc_pkg::CFG_W-1:0]    debounce_time_q, short_limit_q, indicator_hold_q;
	logic                          valid_s1;
	logic [bpdc_pkg::TIME_W-1:0]   time_s1;
	logic                          low_s1;
	logic                          advance;
	bpdc_pkg::press_evt_t          evt;
	logic [bpdc_pkg::TIME_W-1:0]   length;
	logic                          green_next, red_next;
	logic                          out_valid_q;
	logic                          done_q, short_q, green_q, red_q;
	logic [bpdc_pkg::TIME_W-1:0]   length_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= bpdc_pkg::DEBOUNCE_TIME_RST;
			short_limit_q <= bpdc_pkg::SHORT_LIMIT_RST;
			indicator_hold_q <= bpdc_pkg::INDICATOR_HOLD_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				bpdc_pkg::REG_DEBOUNCE_TIME: debounce_time_q <= cfg_data;
				bpdc_pkg::REG_SHORT_LIMIT: short_limit_q <= cfg_data;
				bpdc_pkg::REG_INDICATOR_HOLD: indicator_hold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			time_s1 <= time_ms;
			low_s1 <= button_low;
		end
	end

	bpdc_press_fsm u_press_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.time_ms       (time_s1),
		.button_low    (low_s1),
		.debounce_time (debounce_time_q),
		.short_limit   (short_limit_q),
		.evt           (evt),
		.press_length  (length)
	);

	bpdc_indicator u_indicator (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.time_ms        (time_s1),
		.indicator_hold (indicator_hold_q),
		.evt            (evt),
		.green_next     (green_next),
		.red_next       (red_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q <= evt.done;
			short_q <= evt.is_short;
			length_q <= length;
			green_q <= green_next;
			red_q <= red_next;
		end
	end

	assign out_valid = out_valid_q;
	assign press_done = done_q;
	assign press_length = length_q;
	assign press_short = short_q;
	assign green_light = green_q;
	assign red_light = red_q;

endmodule

// ===== rtl/core/bpdc_press_fsm.sv =====
module bpdc_press_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [bpdc_pkg::TIME_W-1:0]    time_ms,
	input  logic                           button_low,
	input  logic [bpdc_pkg::CFG_W-1:0]     debounce_time,
	input  logic [bpdc_pkg::CFG_W-1:0]     short_limit,
	output bpdc_pkg::press_evt_t           evt,
	output logic [bpdc_pkg::TIME_W-1:0]    press_length
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DOWN,
		PH_PRESSED,
		PH_UP
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic [bpdc_pkg::TIME_W-1:0]   settle_start_q, settle_start_d;
	logic [bpdc_pkg::TIME_W-1:0]   press_begin_q, press_begin_d;
	logic [bpdc_pkg::TIME_W-1:0]   press_finish_q, press_finish_d;
	logic [bpdc_pkg::TIME_W-1:0]   elapsed;
	logic [bpdc_pkg::TIME_W-1:0]   length;
	logic                          settled;

	always_comb begin
		elapsed = time_ms - settle_start_q;
		settled = elapsed >= {{(bpdc_pkg::TIME_W-bpdc_pkg::CFG_W){1'b0}}, debounce_time};
		length = press_finish_q - press_begin_q;
		phase_d = phase_q;
		settle_start_d = settle_start_q;
		press_begin_d = press_begin_q;
		press_finish_d = press_finish_q;
		evt = '0;
		press_length = '0;
		case (phase_q)
			PH_IDLE: begin
				if (button_low) begin
					settle_start_d = time_ms;
					phase_d = PH_DOWN;
				end
			end
			PH_DOWN: begin
				if (!button_low) begin
					phase_d = PH_IDLE;
				end else if (settled) begin
					press_begin_d = time_ms;
					phase_d = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!button_low) begin
					press_finish_d = time_ms;
					settle_start_d = time_ms;
					phase_d = PH_UP;
				end
			end
			PH_UP: begin
				if (button_low) begin
					phase_d = PH_PRESSED;
				end else if (settled) begin
					evt.done = 1'b1;
					evt.is_short = length < {{(bpdc_pkg::TIME_W-bpdc_pkg::CFG_W){1'b0}},
						short_limit};
					press_length = length;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			settle_start_q <= '0;
			press_begin_q <= '0;
			press_finish_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			settle_start_q <= settle_start_d;
			press_begin_q <= press_begin_d;
			press_finish_q <= press_finish_d;
		end
	end

endmodule

// ===== rtl/core/bpdc_indicator.sv =====
module bpdc_indicator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [bpdc_pkg::TIME_W-1:0]    time_ms,
	input  logic [bpdc_pkg::CFG_W-1:0]     indicator_hold,
	input  bpdc_pkg::press_evt_t           evt,
	output logic                           green_next,
	output logic                           red_next
);

	logic                          green_armed_q, red_armed_q;
	logic [bpdc_pkg::TIME_W-1:0]   green_off_time_q, red_off_time_q;
	logic [bpdc_pkg::TIME_W-1:0]   off_time_new;
	logic [bpdc_pkg::TIME_W-1:0]   green_diff, red_diff;
	logic                          set_green, set_red, hold_nonzero;

	always_comb begin
		off_time_new = time_ms + {{(bpdc_pkg::TIME_W-bpdc_pkg::CFG_W){1'b0}}, indicator_hold};
		hold_nonzero = indicator_hold != '0;
		set_green = evt.done && evt.is_short;
		set_red = evt.done && !evt.is_short;
		green_diff = time_ms - green_off_time_q;
		red_diff = time_ms - red_off_time_q;
		// A light set on this sample expires at once only when the hold time is zero.
		if (set_green) begin
			green_next = hold_nonzero;
		end else begin
			green_next = green_armed_q && green_diff[bpdc_pkg::TIME_W-1];
		end
		if (set_red) begin
			red_next = hold_nonzero;
		end else begin
			red_next = red_armed_q && red_diff[bpdc_pkg::TIME_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_armed_q <= 1'b0;
			red_armed_q <= 1'b0;
			green_off_time_q <= '0;
			red_off_time_q <= '0;
		end else if (advance) begin
			green_armed_q <= green_next;
			red_armed_q <= red_next;
			if (set_green) begin
				green_off_time_q <= off_time_new;
			end
			if (set_red) begin
				red_off_time_q <= off_time_new;
			end
		end
	end

endmodule
